### rtl/siet_pkg.sv
// shared types and constants for the sorted interval event table
package siet_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = 5;
	localparam int CNT_W       = 6;
	localparam int MAX_MATCH   = 32;

	localparam logic [2:0] OP_INSERT     = 3'd0;
	localparam logic [2:0] OP_DELETE     = 3'd1;
	localparam logic [2:0] OP_CLEAR      = 3'd2;
	localparam logic [2:0] OP_QUERY_AT   = 3'd3;
	localparam logic [2:0] OP_QUERY_ENT  = 3'd4;
	localparam logic [2:0] OP_QUERY_FIN  = 3'd5;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] start_time;
		logic signed [31:0] end_time;
		logic [4:0]         entry_index;
		logic signed [31:0] prev_time;
		logic signed [31:0] now_time;
		logic               count_passed;
	} cmd_t;

	typedef struct packed {
		logic [4:0]         match_index;
		logic signed [31:0] match_start;
		logic signed [31:0] match_end;
		logic [5:0]         match_count;
		logic [1:0]         status;
		logic               is_summary;
		logic               last;
	} result_t;

	typedef struct packed {
		logic signed [31:0] start_time;
		logic signed [31:0] end_time;
	} entry_t;

	// compare unit outcome for one table entry
	typedef struct packed {
		logic hit;    // entry satisfies the query condition
		logic past;   // entry start lies beyond now_time
		logic place;  // new start goes at or before this entry
	} cmp_t;

endpackage

### rtl/siet_match.sv
// shared compare unit: tests one table entry against the current command
module siet_match (
	input  siet_pkg::cmd_t   cmd,
	input  siet_pkg::entry_t entry,
	output siet_pkg::cmp_t   cmp
);
	import siet_pkg::*;

	logic signed [31:0] st, et, prev, now, new_st;
	logic prev_lt_st, now_ge_st, now_le_et, prev_le_et, skipped;

	always_comb begin
		st     = entry.start_time;
		et     = entry.end_time;
		prev   = cmd.prev_time;
		now    = cmd.now_time;
		new_st = cmd.start_time;

		prev_lt_st = prev < st;
		now_ge_st  = now >= st;
		now_le_et  = now <= et;
		prev_le_et = prev <= et;
		// interval lies wholly between the two times
		skipped    = cmd.count_passed && prev_lt_st && !now_le_et;

		case (cmd.op)
			OP_QUERY_AT: begin
				cmp.hit = now_ge_st && now_le_et;
			end
			OP_QUERY_ENT: begin
				cmp.hit = (prev_lt_st && now_ge_st && now_le_et) || skipped;
			end
			default: begin
				cmp.hit = (!prev_lt_st && prev_le_et && !now_le_et) || skipped;
			end
		endcase

		cmp.past  = !now_ge_st;
		cmp.place = new_st <= st;
	end

endmodule

### rtl/sorted_interval_event_table.sv
// top level of the sorted interval event table
//
//  channel   signals                 direction  transfer
//  command   start, busy, cmd        in         rising edge with start high, busy low
//  result    done, result            out        every cycle with done high, no stall
//
// clear, rejected inserts and deletes and unused op codes answer the cycle after the transfer
// insert: a search for the place, then a shift up that opens a gap there (only the write when appending)
//   and writes the new entry; delete: a shift down above the index; queries: a scan that stops past now_time
// every pass moves one entry per cycle through the entry memory and the one compare unit
// arst_n clears control state and the entry count; entry memory is not cleared
// results cannot be held off: each one shows for exactly one cycle with done
module sorted_interval_event_table (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  siet_pkg::cmd_t    cmd,
	output logic              busy,
	output logic              done,
	output siet_pkg::result_t result
);
	import siet_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT_UP,
		S_SHIFT_DN
	} state_t;

	state_t             state_q;
	cmd_t               cmd_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   ptr_q;     // read pointer; shift up reads the address below it
	logic [CNT_W-1:0]   pos_q;     // insert position
	logic [CNT_W-1:0]   total_q;   // matches seen in this query
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	entry_t             rdata_s1;
	entry_t             rem_q;     // entry taken out by delete
	logic               done_q;
	result_t            result_q;

	// entry memory, one read and one write per cycle
	entry_t             mem [TABLE_DEPTH];
	logic [IDX_W-1:0]   mem_raddr;
	logic [IDX_W-1:0]   mem_waddr;
	logic               mem_we;
	entry_t             mem_wdata;

	cmp_t               cmp;
	logic               is_ins;
	logic               stop;
	logic               issue;
	logic signed [31:0] end_clamped;
	cmd_t               cmd_clamped;

	siet_match u_match (
		.cmd   (cmd_q),
		.entry (rdata_s1),
		.cmp   (cmp)
	);

	function automatic result_t make_result(logic [IDX_W-1:0] idx, logic signed [31:0] st,
			logic signed [31:0] et, logic [CNT_W-1:0] cnt, logic [1:0] stat,
			logic summary, logic fin);
		result_t r;
		r.match_index = idx;
		r.match_start = st;
		r.match_end   = et;
		r.match_count = cnt;
		r.status      = stat;
		r.is_summary  = summary;
		r.last        = fin;
		return r;
	endfunction

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// end time is clamped up to the start on insert
	assign end_clamped = (cmd.end_time < cmd.start_time) ? cmd.start_time : cmd.end_time;
	assign is_ins      = (cmd_q.op == OP_INSERT);

	always_comb begin
		cmd_clamped          = cmd;
		cmd_clamped.end_time = end_clamped;
	end

	// scan stop: insert found its place, or query went past now_time
	assign stop = rd_vld_s1 && (is_ins ? cmp.place : cmp.past);

	always_comb begin
		case (state_q)
			S_SCAN:     issue = (ptr_q < count_q) && !stop;
			S_SHIFT_UP: issue = (ptr_q > pos_q);
			S_SHIFT_DN: issue = (ptr_q < count_q);
			default:    issue = 1'b0;
		endcase
	end

	// shift up reads below the pointer, everything else reads at it
	always_comb begin
		if (state_q == S_SHIFT_UP) begin
			mem_raddr = IDX_W'(ptr_q - CNT_W'(1));
		end else begin
			mem_raddr = ptr_q[IDX_W-1:0];
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_idx_s1;
		mem_wdata = rdata_s1;
		case (state_q)
			S_SHIFT_UP: begin
				if (rd_vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = rd_idx_s1 + IDX_W'(1);
				end else if (ptr_q <= pos_q) begin
					// gap is open: drop the new entry in
					mem_we               = 1'b1;
					mem_waddr            = pos_q[IDX_W-1:0];
					mem_wdata.start_time = cmd_q.start_time;
					mem_wdata.end_time   = cmd_q.end_time;
				end
			end
			S_SHIFT_DN: begin
				if (rd_vld_s1 && (rd_idx_s1 != cmd_q.entry_index)) begin
					mem_we    = 1'b1;
					mem_waddr = rd_idx_s1 - IDX_W'(1);
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			ptr_q     <= '0;
			pos_q     <= '0;
			total_q   <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					rd_vld_s1 <= 1'b0;
					total_q   <= '0;
					if (start) begin
						cmd_q <= cmd_clamped;
						case (cmd.op)
							OP_INSERT: begin
								if (count_q >= CNT_W'(TABLE_DEPTH)) begin
									done_q   <= 1'b1;
									result_q <= make_result('0, '0, '0, count_q,
										STATUS_FULL, 1'b1, 1'b1);
								end else begin
									state_q <= S_SCAN;
									ptr_q   <= '0;
									pos_q   <= count_q;
								end
							end
							OP_DELETE: begin
								if ({1'b0, cmd.entry_index} >= count_q) begin
									done_q   <= 1'b1;
									result_q <= make_result('0, '0, '0, count_q,
										STATUS_BAD_INDEX, 1'b1, 1'b1);
								end else begin
									state_q <= S_SHIFT_DN;
									ptr_q   <= {1'b0, cmd.entry_index};
								end
							end
							OP_CLEAR: begin
								count_q  <= '0;
								done_q   <= 1'b1;
								result_q <= make_result('0, '0, '0, '0,
									STATUS_OK, 1'b1, 1'b1);
							end
							OP_QUERY_AT, OP_QUERY_ENT, OP_QUERY_FIN: begin
								state_q <= S_SCAN;
								ptr_q   <= '0;
							end
							default: begin
								done_q   <= 1'b1;
								result_q <= make_result('0, '0, '0, count_q,
									STATUS_OK, 1'b1, 1'b1);
							end
						endcase
					end
				end

				S_SCAN: begin
					rd_vld_s1 <= issue;
					rd_idx_s1 <= ptr_q[IDX_W-1:0];
					if (issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					// match item, only the first MAX_MATCH are sent
					if (rd_vld_s1 && !stop && !is_ins && cmp.hit) begin
						total_q <= total_q + CNT_W'(1);
						if (total_q < CNT_W'(MAX_MATCH)) begin
							done_q   <= 1'b1;
							result_q <= make_result(rd_idx_s1, rdata_s1.start_time,
								rdata_s1.end_time, '0, STATUS_OK, 1'b0, 1'b0);
						end
					end
					if (stop || (!rd_vld_s1 && (ptr_q >= count_q))) begin
						rd_vld_s1 <= 1'b0;
						if (is_ins) begin
							state_q <= S_SHIFT_UP;
							ptr_q   <= count_q;
							if (stop) begin
								pos_q <= {1'b0, rd_idx_s1};
							end
						end else begin
							state_q  <= S_IDLE;
							done_q   <= 1'b1;
							result_q <= make_result('0, '0, '0, total_q,
								STATUS_OK, 1'b1, 1'b1);
						end
					end
				end

				S_SHIFT_UP: begin
					rd_vld_s1 <= issue;
					rd_idx_s1 <= IDX_W'(ptr_q - CNT_W'(1));
					if (issue) begin
						ptr_q <= ptr_q - CNT_W'(1);
					end
					if (!rd_vld_s1 && (ptr_q <= pos_q)) begin
						state_q  <= S_IDLE;
						count_q  <= count_q + CNT_W'(1);
						done_q   <= 1'b1;
						result_q <= make_result(pos_q[IDX_W-1:0], cmd_q.start_time,
							cmd_q.end_time, count_q + CNT_W'(1), STATUS_OK, 1'b1, 1'b1);
					end
				end

				S_SHIFT_DN: begin
					rd_vld_s1 <= issue;
					rd_idx_s1 <= ptr_q[IDX_W-1:0];
					if (issue) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (rd_vld_s1 && (rd_idx_s1 == cmd_q.entry_index)) begin
						rem_q <= rdata_s1;
					end
					if (!rd_vld_s1 && (ptr_q >= count_q)) begin
						state_q  <= S_IDLE;
						count_q  <= count_q - CNT_W'(1);
						done_q   <= 1'b1;
						result_q <= make_result(cmd_q.entry_index, rem_q.start_time,
							rem_q.end_time, count_q - CNT_W'(1), STATUS_OK, 1'b1, 1'b1);
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/siet_checker.sv
// port-level checks for the sorted interval event table, bound to the top level
module siet_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input siet_pkg::result_t result
);
	import siet_pkg::*;

	// the block only goes busy after a command transfer
	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a command");

	// a non-final item means more items follow, so the block still works
	a_more_pending: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.last |-> busy)
		else $error("non-final result while idle");

	a_summary_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.is_summary |-> result.last)
		else $error("summary item not marked last");

	a_match_item: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.is_summary |-> (result.match_count == '0) &&
			(result.status == STATUS_OK))
		else $error("match item carries count or status");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == STATUS_FULL) |->
			(result.match_count == 6'(TABLE_DEPTH)))
		else $error("table full reported below depth");

endmodule

bind sorted_interval_event_table siet_checker u_siet_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
